>>> rtl/core/world_to_screen_projection_defines.svh
// Assertion macros for the world to screen projection block.
// Used by the port checker; no other dependencies.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Implication checked in the same cycle, off while reset is asserted
`define WTSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wtsp check failed");

// Implication checked in the next cycle
`define WTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wtsp check failed");

`endif

>>> rtl/core/wtsp_pkg.sv
// Shared types and constants for the world to screen projection block.
// No dependencies.
`default_nettype none

package wtsp_pkg;

	localparam int MATRIX_FRAC_BITS_DEF = 12;
	localparam int COORD_W    = 32;
	localparam int ENTRY_W    = 16;
	localparam int VIEW_W     = 14;
	localparam int HALF_W     = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PROD_W     = 48;
	localparam int CLIP_W     = 50;
	localparam int NUM_W      = 64;
	localparam int MAG_W      = 63;
	localparam int QUO_W      = 40;
	localparam int PRE_W      = 24;
	localparam int REM_W      = CLIP_W - 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COL_X,
		REG_COL_Y,
		REG_COL_Z,
		REG_COL_T,
		REG_VP_W,
		REG_VP_H
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] world_x;
		logic signed [COORD_W-1:0] world_y;
		logic signed [COORD_W-1:0] world_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic                      visible;
	} screen_t;

endpackage

`default_nettype wire

>>> rtl/core/world_to_screen_projection.sv
// Top level of the world to screen projection pipeline.
// Depends on wtsp_pkg.
//
// Takes one world point per clock and returns one screen word from the
// final stage, marked by result_valid for a single cycle; results cannot
// be held off, so there is no stall and busy stays low. Clip w divides x
// and y in a 40 stage restoring divider, one quotient bit a stage. The
// user must write configuration only while no points are in flight; the
// block itself does not enforce this.
`default_nettype none

module world_to_screen_projection #(
	parameter int MATRIX_FRAC_BITS = wtsp_pkg::MATRIX_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire wtsp_pkg::point_t               point,
	output      logic                           result_valid,
	output      wtsp_pkg::screen_t              result,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [wtsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wtsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wtsp_pkg::*;

	localparam int VIS_W = CLIP_W + 4;
	localparam logic signed [VIS_W-1:0] VIS_LIM =
		$signed(VIS_W'(64'd1 << (16 + MATRIX_FRAC_BITS)));

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} div_lane_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [CLIP_W-1:0] v);
		logic signed [CLIP_W-1:0] hi;
		logic signed [CLIP_W-1:0] lo;
		hi = CLIP_W'(64'sh7FFF_FFFF);
		lo = -CLIP_W'(64'sh8000_0000);
		if (v > hi) return hi[COORD_W-1:0];
		if (v < lo) return lo[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	// Configuration registers
	logic [CFG_DATA_W-1:0] col_q [4];
	logic [VIEW_W-1:0]     vp_w_q;
	logic [VIEW_W-1:0]     vp_h_q;
	logic [HALF_W-1:0]     hw;
	logic [HALF_W-1:0]     hh;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign hw        = vp_w_q[VIEW_W-1:1];
	assign hh        = vp_h_q[VIEW_W-1:1];

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) col_q[i] <= '0;
			vp_w_q <= VIEW_W'(1024);
			vp_h_q <= VIEW_W'(768);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COL_X: col_q[0] <= cfg_data;
				REG_COL_Y: col_q[1] <= cfg_data;
				REG_COL_Z: col_q[2] <= cfg_data;
				REG_COL_T: col_q[3] <= cfg_data;
				REG_VP_W:  vp_w_q <= cfg_data[VIEW_W-1:0];
				REG_VP_H:  vp_h_q <= cfg_data[VIEW_W-1:0];
				default: ;
			endcase
		end
	end

	// Matrix entries for clip rows x, y and w (row z is never used)
	logic signed [ENTRY_W-1:0] ent [3][4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			ent[0][c] = col_q[c][0*ENTRY_W +: ENTRY_W];
			ent[1][c] = col_q[c][1*ENTRY_W +: ENTRY_W];
			ent[2][c] = col_q[c][3*ENTRY_W +: ENTRY_W];
		end
	end

	logic                      v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0]  prod_s1 [3][3];
	logic signed [CLIP_W-1:0]  clip_s2 [3];
	logic signed [NUM_W-1:0]   numx_s3, numy_s3;
	logic [REM_W-1:0]          den_s3;
	logic                      vis_s3;

	logic                      dv_s   [QUO_W+1];
	logic                      dvis_s [QUO_W+1];
	logic [REM_W-1:0]          dden_s [QUO_W+1];
	div_lane_t                 dx_s   [QUO_W+1];
	div_lane_t                 dy_s   [QUO_W+1];

	// Valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k <= QUO_W; k++) dv_s[k] <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			dv_s[0] <= v_s3;
			for (int k = 0; k < QUO_W; k++) dv_s[k+1] <= dv_s[k];
			result_valid <= dv_s[QUO_W];
		end
	end

	// Stage 1: nine products of point and matrix entries
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			prod_s1[r][0] <= point.world_x * ent[r][0];
			prod_s1[r][1] <= point.world_y * ent[r][1];
			prod_s1[r][2] <= point.world_z * ent[r][2];
		end
	end

	// Stage 2: clip coordinates with translation
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			clip_s2[r] <= CLIP_W'(prod_s1[r][0]) + CLIP_W'(prod_s1[r][1])
				+ CLIP_W'(prod_s1[r][2]) + (CLIP_W'(ent[r][3]) <<< 16);
		end
	end

	// Stage 3: scale by half size, test w against 0.1
	logic signed [VIS_W-1:0] cw10;
	assign cw10 = (VIS_W'(clip_s2[2]) <<< 3) + (VIS_W'(clip_s2[2]) <<< 1);

	always_ff @(posedge clk) begin
		numx_s3 <= $signed({1'b0, hw}) * clip_s2[0];
		numy_s3 <= $signed({1'b0, hh}) * clip_s2[1];
		den_s3  <= clip_s2[2][REM_W-1:0];
		vis_s3  <= cw10 >= VIS_LIM;
	end

	// Stage 4: magnitudes, overflow test and divider set-up
	logic [NUM_W-1:0] magx, magy;
	assign magx = numx_s3[NUM_W-1] ? NUM_W'(-numx_s3) : NUM_W'(numx_s3);
	assign magy = numy_s3[NUM_W-1] ? NUM_W'(-numy_s3) : NUM_W'(numy_s3);

	always_ff @(posedge clk) begin
		dvis_s[0]   <= vis_s3;
		dden_s[0]   <= den_s3;
		dx_s[0].rem <= REM_W'(magx[MAG_W-1:PRE_W]);
		dx_s[0].low <= {magx[PRE_W-1:0], 16'b0};
		dx_s[0].quo <= '0;
		dx_s[0].neg <= numx_s3[NUM_W-1];
		dx_s[0].ovf <= REM_W'(magx[MAG_W-1:PRE_W]) >= den_s3;
		dy_s[0].rem <= REM_W'(magy[MAG_W-1:PRE_W]);
		dy_s[0].low <= {magy[PRE_W-1:0], 16'b0};
		dy_s[0].quo <= '0;
		dy_s[0].neg <= numy_s3[NUM_W-1];
		dy_s[0].ovf <= REM_W'(magy[MAG_W-1:PRE_W]) >= den_s3;
	end

	// Divider: one quotient bit per stage for both lanes
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [REM_W:0] shx, shy;
		logic           gex, gey;
		assign shx = {dx_s[k].rem, dx_s[k].low[QUO_W-1]};
		assign shy = {dy_s[k].rem, dy_s[k].low[QUO_W-1]};
		assign gex = shx >= {1'b0, dden_s[k]};
		assign gey = shy >= {1'b0, dden_s[k]};

		always_ff @(posedge clk) begin
			dvis_s[k+1]     <= dvis_s[k];
			dden_s[k+1]     <= dden_s[k];
			dx_s[k+1].rem   <= gex ? REM_W'(shx - {1'b0, dden_s[k]}) : shx[REM_W-1:0];
			dx_s[k+1].low   <= dx_s[k].low << 1;
			dx_s[k+1].quo   <= {dx_s[k].quo[QUO_W-2:0], gex};
			dx_s[k+1].neg   <= dx_s[k].neg;
			dx_s[k+1].ovf   <= dx_s[k].ovf;
			dy_s[k+1].rem   <= gey ? REM_W'(shy - {1'b0, dden_s[k]}) : shy[REM_W-1:0];
			dy_s[k+1].low   <= dy_s[k].low << 1;
			dy_s[k+1].quo   <= {dy_s[k].quo[QUO_W-2:0], gey};
			dy_s[k+1].neg   <= dy_s[k].neg;
			dy_s[k+1].ovf   <= dy_s[k].ovf;
		end
	end

	// Final stage: cap, restore sign, add viewport offset, saturate
	logic [QUO_W:0]            mx, my;
	logic signed [QUO_W+1:0]   sqx, sqy;
	logic signed [CLIP_W-1:0]  sumx, sumy;

	always_comb begin
		mx   = dx_s[QUO_W].ovf ? {1'b1, QUO_W'(0)} : {1'b0, dx_s[QUO_W].quo};
		my   = dy_s[QUO_W].ovf ? {1'b1, QUO_W'(0)} : {1'b0, dy_s[QUO_W].quo};
		sqx  = dx_s[QUO_W].neg ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
		sqy  = dy_s[QUO_W].neg ? -$signed({1'b0, my}) : $signed({1'b0, my});
		sumx = CLIP_W'(sqx) + $signed(CLIP_W'({hw, 16'b0}));
		sumy = $signed(CLIP_W'({hh, 16'b0})) - CLIP_W'(sqy);
	end

	always_ff @(posedge clk) begin
		if (dvis_s[QUO_W]) begin
			result.screen_x <= sat32(sumx);
			result.screen_y <= sat32(sumy);
			result.visible  <= 1'b1;
		end else begin
			result.screen_x <= '0;
			result.screen_y <= '0;
			result.visible  <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/wtsp_checker.sv
// Port checker for the world to screen projection block, bound to the top.
// Depends on wtsp_pkg and world_to_screen_projection_defines.svh.
`default_nettype none
`include "world_to_screen_projection_defines.svh"

module wtsp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              busy,
	input wire logic              cfg_ready,
	input wire logic              result_valid,
	input wire wtsp_pkg::screen_t result
);
	import wtsp_pkg::*;

	// A hidden point gives a zero screen word
	`WTSP_ASSERT_NOW(a_hidden_zero, clk, arst_n, result_valid && !result.visible, result.screen_x == '0 && result.screen_y == '0)
	// The pipeline never refuses a word
	`WTSP_ASSERT_NEXT(a_never_busy, clk, arst_n, 1'b1, !busy && cfg_ready)
	// Nonzero coordinates only come with the visible bit set
	`WTSP_ASSERT_NOW(a_vis_bit, clk, arst_n, result_valid && (result.screen_x != '0 || result.screen_y != '0), result.visible)

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.cfg_ready    (cfg_ready),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
